// ===== hdl/bgc_pkg.sv =====
// ----------------------------------------------------------------------------
// bgc_pkg
// Shared types and constants of the bilinear gradient color block.
// ----------------------------------------------------------------------------
package bgc_pkg;

  localparam int CH_W      = 8;
  localparam int NCH       = 3;
  localparam int PIX_W     = 12;
  localparam int DIM_W     = 13;
  localparam int CFG_DW    = 24;
  localparam int CFG_IDX_W = 3;
  localparam int QBITS     = 8;

  localparam logic [CFG_DW-1:0] RESET_TL = 24'hFF0000;
  localparam logic [CFG_DW-1:0] RESET_TR = 24'h0000FF;
  localparam logic [CFG_DW-1:0] RESET_BL = 24'hFFFF00;
  localparam logic [CFG_DW-1:0] RESET_BR = 24'h00FF00;
  localparam logic [DIM_W-1:0]  RESET_W  = 13'd640;
  localparam logic [DIM_W-1:0]  RESET_H  = 13'd480;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_TL = 3'd0,
    CFG_TR = 3'd1,
    CFG_BL = 3'd2,
    CFG_BR = 3'd3,
    CFG_W  = 3'd4,
    CFG_H  = 3'd5
  } cfg_idx_e;

  typedef struct packed {
    logic [CFG_DW-1:0] tl;
    logic [CFG_DW-1:0] tr;
    logic [CFG_DW-1:0] bl;
    logic [CFG_DW-1:0] br;
    logic [DIM_W-1:0]  w;
    logic [DIM_W-1:0]  h;
  } cfg_t;

endpackage

// ===== hdl/bgc_cfg.sv =====
// ----------------------------------------------------------------------------
// bgc_cfg
// Configuration register file: corner colors and frame size.
// ----------------------------------------------------------------------------
module bgc_cfg (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [bgc_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  logic [bgc_pkg::CFG_DW-1:0]      cfg_wdata_i,
  output bgc_pkg::cfg_t                   cfg_o
);
  import bgc_pkg::*;

  cfg_t cfg_d, cfg_q;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        CFG_TL:  cfg_d.tl = cfg_wdata_i;
        CFG_TR:  cfg_d.tr = cfg_wdata_i;
        CFG_BL:  cfg_d.bl = cfg_wdata_i;
        CFG_BR:  cfg_d.br = cfg_wdata_i;
        CFG_W:   cfg_d.w  = cfg_wdata_i[DIM_W-1:0];
        CFG_H:   cfg_d.h  = cfg_wdata_i[DIM_W-1:0];
        default: cfg_d    = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '{tl: RESET_TL, tr: RESET_TR, bl: RESET_BL, br: RESET_BR,
                 w: RESET_W, h: RESET_H};
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

// ===== hdl/bgc_weights.sv =====
// ----------------------------------------------------------------------------
// bgc_weights
// Range check, axis weights and the horizontal blend of the corner colors.
// Two register stages.
// ----------------------------------------------------------------------------
module bgc_weights #(
  parameter int MAX_WIDTH  = 4096,
  parameter int MAX_HEIGHT = 4096,
  parameter int DXW        = 12,
  parameter int DYW        = 12,
  parameter int TW         = 20,
  parameter int DW2        = 24
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        vld_i,
  input  logic [bgc_pkg::PIX_W-1:0]   pixel_x_i,
  input  logic [bgc_pkg::PIX_W-1:0]   pixel_y_i,
  input  bgc_pkg::cfg_t               cfg_i,
  output logic                        vld_o,
  output logic                        oor_o,
  output logic [TW-1:0]               top_o [bgc_pkg::NCH],
  output logic [TW-1:0]               bot_o [bgc_pkg::NCH],
  output logic [DW2-1:0]              den_o,
  output logic [DYW-1:0]              ny_o,
  output logic [DYW-1:0]              dym_o
);
  import bgc_pkg::*;

  function automatic logic [CH_W-1:0] chan(input logic [CFG_DW-1:0] c, input int k);
    chan = c[CH_W*(NCH-1-k) +: CH_W];
  endfunction

  logic [DIM_W-1:0] wc, hc;
  logic             w_one, h_one;
  logic             oor_d;
  logic [DXW-1:0]   nx_d, dx_d;
  logic [DYW-1:0]   ny_d, dy_d;

  logic             s1_vld_q, s1_oor_q;
  logic [DXW-1:0]   nx_q, dxm_q, dx_q;
  logic [DYW-1:0]   ny1_q, dym1_q, dy_q;

  logic [TW-1:0]    top_d [NCH];
  logic [TW-1:0]    bot_d [NCH];
  logic             s2_vld_q, s2_oor_q;
  logic [TW-1:0]    top_q [NCH];
  logic [TW-1:0]    bot_q [NCH];
  logic [DW2-1:0]   den_q;
  logic [DYW-1:0]   ny2_q, dym2_q;

  always_comb begin
    wc    = (int'(cfg_i.w) > MAX_WIDTH)  ? DIM_W'(MAX_WIDTH)  : cfg_i.w;
    hc    = (int'(cfg_i.h) > MAX_HEIGHT) ? DIM_W'(MAX_HEIGHT) : cfg_i.h;
    oor_d = (DIM_W'(pixel_x_i) >= wc) || (DIM_W'(pixel_y_i) >= hc);
    w_one = (wc == DIM_W'(1));
    h_one = (hc == DIM_W'(1));
    nx_d  = w_one ? '0 : DXW'(pixel_x_i);
    dx_d  = w_one ? DXW'(1) : DXW'(wc - DIM_W'(1));
    ny_d  = h_one ? '0 : DYW'(pixel_y_i);
    dy_d  = h_one ? DYW'(1) : DYW'(hc - DIM_W'(1));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q <= 1'b0;
      s2_vld_q <= 1'b0;
    end else begin
      s1_vld_q <= vld_i;
      s2_vld_q <= s1_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    s1_oor_q <= oor_d;
    nx_q     <= nx_d;
    dxm_q    <= dx_d - nx_d;
    dx_q     <= dx_d;
    ny1_q    <= ny_d;
    dym1_q   <= dy_d - ny_d;
    dy_q     <= dy_d;
  end

  always_comb begin
    for (int k = 0; k < NCH; k++) begin
      top_d[k] = TW'(chan(cfg_i.tl, k)) * TW'(dxm_q) + TW'(chan(cfg_i.tr, k)) * TW'(nx_q);
      bot_d[k] = TW'(chan(cfg_i.bl, k)) * TW'(dxm_q) + TW'(chan(cfg_i.br, k)) * TW'(nx_q);
    end
  end

  always_ff @(posedge clk_i) begin
    s2_oor_q <= s1_oor_q;
    top_q    <= top_d;
    bot_q    <= bot_d;
    den_q    <= DW2'(dx_q) * DW2'(dy_q);
    ny2_q    <= ny1_q;
    dym2_q   <= dym1_q;
  end

  assign vld_o = s2_vld_q;
  assign oor_o = s2_oor_q;
  assign top_o = top_q;
  assign bot_o = bot_q;
  assign den_o = den_q;
  assign ny_o  = ny2_q;
  assign dym_o = dym2_q;

endmodule

// ===== hdl/bgc_vblend.sv =====
// ----------------------------------------------------------------------------
// bgc_vblend
// Vertical blend to the exact weighted sum, then the rounding offset:
// numerator 2*S + D and divisor 2*D. Two register stages.
// ----------------------------------------------------------------------------
module bgc_vblend #(
  parameter int DYW = 12,
  parameter int TW  = 20,
  parameter int DW2 = 24,
  parameter int SW  = 32,
  parameter int NW  = 33
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  vld_i,
  input  logic                  oor_i,
  input  logic [TW-1:0]         top_i [bgc_pkg::NCH],
  input  logic [TW-1:0]         bot_i [bgc_pkg::NCH],
  input  logic [DW2-1:0]        den_i,
  input  logic [DYW-1:0]        ny_i,
  input  logic [DYW-1:0]        dym_i,
  output logic                  vld_o,
  output logic                  oor_o,
  output logic [NW-1:0]         num_o [bgc_pkg::NCH],
  output logic [DW2:0]          den2_o
);
  import bgc_pkg::*;

  logic [SW-1:0]  sum_d [NCH];
  logic [SW-1:0]  sum_q [NCH];
  logic [DW2-1:0] den_q;
  logic           s3_vld_q, s3_oor_q;

  logic [NW-1:0]  num_d [NCH];
  logic [NW-1:0]  num_q [NCH];
  logic [DW2:0]   den2_q;
  logic           s4_vld_q, s4_oor_q;

  always_comb begin
    for (int k = 0; k < NCH; k++) begin
      sum_d[k] = SW'(top_i[k]) * SW'(dym_i) + SW'(bot_i[k]) * SW'(ny_i);
    end
  end

  always_comb begin
    for (int k = 0; k < NCH; k++) begin
      num_d[k] = (NW'(sum_q[k]) << 1) + NW'(den_q);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s3_vld_q <= 1'b0;
      s4_vld_q <= 1'b0;
    end else begin
      s3_vld_q <= vld_i;
      s4_vld_q <= s3_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    sum_q    <= sum_d;
    den_q    <= den_i;
    s3_oor_q <= oor_i;
    num_q    <= num_d;
    den2_q   <= {den_q, 1'b0};
    s4_oor_q <= s3_oor_q;
  end

  assign vld_o  = s4_vld_q;
  assign oor_o  = s4_oor_q;
  assign num_o  = num_q;
  assign den2_o = den2_q;

endmodule

// ===== hdl/bgc_div.sv =====
// ----------------------------------------------------------------------------
// bgc_div
// Pipelined restoring divider for the three channels, one quotient bit per
// stage, most significant bit first. The quotient is known to fit QBITS.
// ----------------------------------------------------------------------------
module bgc_div #(
  parameter int DW2 = 24,
  parameter int NW  = 33
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        vld_i,
  input  logic                        oor_i,
  input  logic [NW-1:0]               num_i [bgc_pkg::NCH],
  input  logic [DW2:0]                den2_i,
  output logic                        vld_o,
  output logic                        oor_o,
  output logic [bgc_pkg::CH_W-1:0]    quo_o [bgc_pkg::NCH]
);
  import bgc_pkg::*;

  logic             vld_q [QBITS];
  logic             oor_q [QBITS];
  logic [DW2:0]     dv_q  [QBITS];
  logic [NW-1:0]    rem_q [QBITS][NCH];
  logic [QBITS-1:0] quo_q [QBITS][NCH];

  for (genvar s = 0; s < QBITS; s++) begin : g_stage
    localparam int SH = QBITS - 1 - s;

    logic           vld_in, oor_in;
    logic [DW2:0]   dv_in;
    logic [NW-1:0]  rem_in [NCH];
    logic [QBITS-1:0] quo_in [NCH];
    logic [NW-1:0]  shifted;
    logic [NW-1:0]  rem_d [NCH];
    logic [QBITS-1:0] quo_d [NCH];

    if (s == 0) begin : g_first
      always_comb begin
        vld_in = vld_i;
        oor_in = oor_i;
        dv_in  = den2_i;
        for (int k = 0; k < NCH; k++) begin
          rem_in[k] = num_i[k];
          quo_in[k] = '0;
        end
      end
    end else begin : g_next
      always_comb begin
        vld_in = vld_q[s-1];
        oor_in = oor_q[s-1];
        dv_in  = dv_q[s-1];
        for (int k = 0; k < NCH; k++) begin
          rem_in[k] = rem_q[s-1][k];
          quo_in[k] = quo_q[s-1][k];
        end
      end
    end

    always_comb begin
      shifted = NW'(dv_in) << SH;
      for (int k = 0; k < NCH; k++) begin
        if (rem_in[k] >= shifted) begin
          rem_d[k] = rem_in[k] - shifted;
          quo_d[k] = {quo_in[k][QBITS-2:0], 1'b1};
        end else begin
          rem_d[k] = rem_in[k];
          quo_d[k] = {quo_in[k][QBITS-2:0], 1'b0};
        end
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[s] <= 1'b0;
      end else begin
        vld_q[s] <= vld_in;
      end
    end

    always_ff @(posedge clk_i) begin
      oor_q[s] <= oor_in;
      dv_q[s]  <= dv_in;
      rem_q[s] <= rem_d;
      quo_q[s] <= quo_d;
    end
  end

  assign vld_o = vld_q[QBITS-1];
  assign oor_o = oor_q[QBITS-1];

  always_comb begin
    for (int k = 0; k < NCH; k++) begin
      quo_o[k] = CH_W'(quo_q[QBITS-1][k]);
    end
  end

endmodule

// ===== hdl/bilinear_gradient_color.sv =====
// ----------------------------------------------------------------------------
// bilinear_gradient_color
// Bilinear blend of four corner colors at a pixel coordinate, rounded to
// nearest (ties up) per 8-bit channel; coordinates outside the frame give
// black and raise out_of_range_o.
//
//   channel   handshake          payload
//   -------   ----------------   ----------------------------------------
//   pixel     start / busy       pixel_x_i, pixel_y_i
//   color     valid_o (strobe)   red_o, green_o, blue_o, out_of_range_o
//   config    cfg_we_i           cfg_idx_i, cfg_wdata_i
//
// One item is taken in every cycle; busy stays low.
// Each result passes through two weight stages, two blend stages, eight
// divider stages (one quotient bit each) and the output register.
// Results leave in the order items came in.
// Reset empties the pipeline and loads the default corners and frame size.
// ----------------------------------------------------------------------------
module bilinear_gradient_color #(
  parameter int MAX_WIDTH  = 4096,
  parameter int MAX_HEIGHT = 4096
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start,
  output logic                          busy,
  input  logic [bgc_pkg::PIX_W-1:0]     pixel_x_i,
  input  logic [bgc_pkg::PIX_W-1:0]     pixel_y_i,
  output logic                          valid_o,
  output logic [bgc_pkg::CH_W-1:0]      red_o,
  output logic [bgc_pkg::CH_W-1:0]      green_o,
  output logic [bgc_pkg::CH_W-1:0]      blue_o,
  output logic                          out_of_range_o,
  input  logic                          cfg_we_i,
  input  logic [bgc_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [bgc_pkg::CFG_DW-1:0]    cfg_wdata_i
);
  import bgc_pkg::*;

  localparam int DIM_MAX = (1 << DIM_W) - 1;
  localparam int WLIM    = (MAX_WIDTH  < DIM_MAX) ? MAX_WIDTH  : DIM_MAX;
  localparam int HLIM    = (MAX_HEIGHT < DIM_MAX) ? MAX_HEIGHT : DIM_MAX;
  localparam int DXW     = $clog2(WLIM);
  localparam int DYW     = $clog2(HLIM);
  localparam int TW      = CH_W + DXW;
  localparam int DW2     = DXW + DYW;
  localparam int SW      = CH_W + DW2;
  localparam int NW      = SW + 1;

  cfg_t           cfg;
  logic           accept;

  logic           w_vld, w_oor;
  logic [TW-1:0]  w_top [NCH];
  logic [TW-1:0]  w_bot [NCH];
  logic [DW2-1:0] w_den;
  logic [DYW-1:0] w_ny, w_dym;

  logic           v_vld, v_oor;
  logic [NW-1:0]  v_num [NCH];
  logic [DW2:0]   v_den2;

  logic           d_vld, d_oor;
  logic [CH_W-1:0] d_quo [NCH];

  logic           out_vld_q;
  logic           out_oor_q;
  logic [CH_W-1:0] red_q, green_q, blue_q;

  assign busy   = 1'b0;
  assign accept = start && !busy;

  bgc_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cfg_o       (cfg)
  );

  bgc_weights #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT),
    .DXW        (DXW),
    .DYW        (DYW),
    .TW         (TW),
    .DW2        (DW2)
  ) u_weights (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .vld_i     (accept),
    .pixel_x_i (pixel_x_i),
    .pixel_y_i (pixel_y_i),
    .cfg_i     (cfg),
    .vld_o     (w_vld),
    .oor_o     (w_oor),
    .top_o     (w_top),
    .bot_o     (w_bot),
    .den_o     (w_den),
    .ny_o      (w_ny),
    .dym_o     (w_dym)
  );

  bgc_vblend #(
    .DYW (DYW),
    .TW  (TW),
    .DW2 (DW2),
    .SW  (SW),
    .NW  (NW)
  ) u_vblend (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .vld_i  (w_vld),
    .oor_i  (w_oor),
    .top_i  (w_top),
    .bot_i  (w_bot),
    .den_i  (w_den),
    .ny_i   (w_ny),
    .dym_i  (w_dym),
    .vld_o  (v_vld),
    .oor_o  (v_oor),
    .num_o  (v_num),
    .den2_o (v_den2)
  );

  bgc_div #(
    .DW2 (DW2),
    .NW  (NW)
  ) u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .vld_i  (v_vld),
    .oor_i  (v_oor),
    .num_i  (v_num),
    .den2_i (v_den2),
    .vld_o  (d_vld),
    .oor_o  (d_oor),
    .quo_o  (d_quo)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else begin
      out_vld_q <= d_vld;
    end
  end

  always_ff @(posedge clk_i) begin
    out_oor_q <= d_oor;
    red_q     <= d_oor ? '0 : d_quo[0];
    green_q   <= d_oor ? '0 : d_quo[1];
    blue_q    <= d_oor ? '0 : d_quo[2];
  end

  assign valid_o        = out_vld_q;
  assign out_of_range_o = out_oor_q;
  assign red_o          = red_q;
  assign green_o        = green_q;
  assign blue_o         = blue_q;

  a_latency_fwd : assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |-> ##13 valid_o)
    else $error("item taken without a result 13 cycles later");

  a_latency_bwd : assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> $past(accept, 13))
    else $error("result without a matching item");

  a_oor_black : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_o && out_of_range_o) |-> (red_o == '0 && green_o == '0 && blue_o == '0))
    else $error("out-of-range result carries color");

endmodule

// ===== tb/tb_bilinear_gradient_color.sv =====
// ----------------------------------------------------------------------------
// tb_bilinear_gradient_color
// Self-checking bench for the bilinear gradient color block. A directed table
// covers the corners, frame edges, degenerate and clamped frame sizes, unused
// register indexes and round-half-up ties. Random phases then reprogram the
// corners and frame size and send pixel items, at random gaps or back to back.
// Every color is checked field by field: table value or in-bench predictor.
// ----------------------------------------------------------------------------
module tb_bilinear_gradient_color;
  timeunit 1ns;
  timeprecision 1ps;

  import bgc_pkg::*;

  localparam int PERIOD       = 10;
  localparam int MAX_DIM_X    = 4096;
  localparam int MAX_DIM_Y    = 4096;
  localparam int PIPE_DEPTH   = 13;
  localparam int IDLE_LIMIT   = 2000;
  localparam int RANDOM_ITEMS = 1250;
  localparam int PHASES       = 10;
  localparam int MAX_GAP      = 10;

  localparam logic [CFG_IDX_W-1:0] IDX_SPARE_LO = 3'd6;
  localparam logic [CFG_IDX_W-1:0] IDX_SPARE_HI = 3'd7;

  typedef struct packed {
    logic [CH_W-1:0] red;
    logic [CH_W-1:0] green;
    logic [CH_W-1:0] blue;
    logic            oor;
  } color_t;

  typedef struct packed {
    logic [PIX_W-1:0] x;
    logic [PIX_W-1:0] y;
    color_t           color;
  } pending_pixel_t;

  typedef struct packed {
    bit                   is_reg;
    logic [CFG_IDX_W-1:0] idx;
    logic [3*CH_W-1:0]    data;
    logic [PIX_W-1:0]     x;
    logic [PIX_W-1:0]     y;
    bit                   typed;
    color_t               want;
  } step_t;

  localparam color_t OFF_FRAME = color_t'({24'h000000, 1'b0 | 1'b1});

  logic                 clk_i          = 1'b0;
  logic                 rst_ni         = 1'b0;
  logic                 start          = 1'b0;
  logic                 busy;
  logic [PIX_W-1:0]     pixel_x_i      = '0;
  logic [PIX_W-1:0]     pixel_y_i      = '0;
  logic                 valid_o;
  logic [CH_W-1:0]      red_o;
  logic [CH_W-1:0]      green_o;
  logic [CH_W-1:0]      blue_o;
  logic                 out_of_range_o;
  logic                 cfg_we_i       = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_idx_i      = '0;
  logic [3*CH_W-1:0]    cfg_wdata_i    = '0;

  cfg_t           regs;
  pending_pixel_t pending[$];
  step_t          script[$];
  int             error_count = 0;
  int             idle_cycles = 0;

  bilinear_gradient_color #(
    .MAX_WIDTH (MAX_DIM_X),
    .MAX_HEIGHT(MAX_DIM_Y)
  ) uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start         (start),
    .busy          (busy),
    .pixel_x_i     (pixel_x_i),
    .pixel_y_i     (pixel_y_i),
    .valid_o       (valid_o),
    .red_o         (red_o),
    .green_o       (green_o),
    .blue_o        (blue_o),
    .out_of_range_o(out_of_range_o),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_wdata_i   (cfg_wdata_i)
  );

  always #(PERIOD/2) clk_i = ~clk_i;

  task automatic flag_error(string msg);
    $display("%0t ns  mismatch: %s", $realtime, msg);
    error_count++;
  endtask

  function automatic longint unsigned clamp_dim(logic [DIM_W-1:0] d, int lim);
    return (d > lim) ? longint'(lim) : longint'(d);
  endfunction

  function automatic color_t blend_color(logic [PIX_W-1:0] x, logic [PIX_W-1:0] y);
    longint unsigned w, h, nx, dx, ny, dy, den, wtl, wtr, wbl, wbr, s, v;
    color_t c;
    w = clamp_dim(regs.w, MAX_DIM_X);
    h = clamp_dim(regs.h, MAX_DIM_Y);
    c = '0;
    if (x >= w || y >= h) begin
      c.oor = 1'b1;
      return c;
    end
    if (w <= 1) begin
      nx = 0;
      dx = 1;
    end else begin
      nx = x;
      dx = w - 1;
    end
    if (h <= 1) begin
      ny = 0;
      dy = 1;
    end else begin
      ny = y;
      dy = h - 1;
    end
    den = dx * dy;
    wtl = (dx - nx) * (dy - ny);
    wtr = nx * (dy - ny);
    wbl = (dx - nx) * ny;
    wbr = nx * ny;
    for (int k = 0; k < NCH; k++) begin
      s = longint'(regs.tl[8*(2-k) +: 8]) * wtl + longint'(regs.tr[8*(2-k) +: 8]) * wtr
        + longint'(regs.bl[8*(2-k) +: 8]) * wbl + longint'(regs.br[8*(2-k) +: 8]) * wbr;
      v = (64'd2 * s + den) / (64'd2 * den);
      if (v > 255) v = 255;
      c[8*(3-k) -: 8] = v[7:0];
    end
    return c;
  endfunction

  // check every strobed color against the oldest outstanding item
  always @(posedge clk_i) begin : check_colors
    pending_pixel_t head;
    if (!rst_ni) begin
      idle_cycles = 0;
    end else begin
      if ((start && !busy) || valid_o) idle_cycles = 0;
      else idle_cycles++;
      if (valid_o) begin
        if (pending.size() == 0) begin
          flag_error("color strobed with no item outstanding");
        end else begin
          head = pending.pop_front();
          if (red_o !== head.color.red)
            flag_error($sformatf("(%0d,%0d) red %0h, want %0h", head.x, head.y,
                                 red_o, head.color.red));
          if (green_o !== head.color.green)
            flag_error($sformatf("(%0d,%0d) green %0h, want %0h", head.x, head.y,
                                 green_o, head.color.green));
          if (blue_o !== head.color.blue)
            flag_error($sformatf("(%0d,%0d) blue %0h, want %0h", head.x, head.y,
                                 blue_o, head.color.blue));
          if (out_of_range_o !== head.color.oor)
            flag_error($sformatf("(%0d,%0d) out_of_range %0b, want %0b", head.x, head.y,
                                 out_of_range_o, head.color.oor));
        end
      end
    end
  end

  initial begin
    wait (rst_ni);
    while (idle_cycles < IDLE_LIMIT) @(posedge clk_i);
    $display("%0t ns  watchdog: no progress", $realtime);
    $display("tb_bilinear_gradient_color: errors");
    $finish;
  end

  // call at a falling edge; returns at the falling edge after acceptance
  task automatic issue_pixel(logic [PIX_W-1:0] x, logic [PIX_W-1:0] y, int gap,
                             bit typed, color_t want);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    start     <= 1'b1;
    pixel_x_i <= x;
    pixel_y_i <= y;
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
    pending.push_back('{x, y, typed ? want : blend_color(x, y)});
    @(negedge clk_i);
  endtask

  task automatic drain_pipeline();
    start <= 1'b0;
    while (pending.size() > 0) @(negedge clk_i);
    repeat (PIPE_DEPTH + 4) @(negedge clk_i);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [3*CH_W-1:0] data);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= data;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      CFG_TL:  regs.tl = data;
      CFG_TR:  regs.tr = data;
      CFG_BL:  regs.bl = data;
      CFG_BR:  regs.br = data;
      CFG_W:   regs.w  = data[DIM_W-1:0];
      CFG_H:   regs.h  = data[DIM_W-1:0];
      default: ;
    endcase
    @(negedge clk_i);
  endtask

  function automatic void add_reg(logic [CFG_IDX_W-1:0] idx, logic [3*CH_W-1:0] data);
    script.push_back('{1'b1, idx, data, '0, '0, 1'b0, '0});
  endfunction

  function automatic void add_pixel(logic [PIX_W-1:0] x, logic [PIX_W-1:0] y);
    script.push_back('{1'b0, '0, '0, x, y, 1'b0, '0});
  endfunction

  function automatic void add_pixel_want(logic [PIX_W-1:0] x, logic [PIX_W-1:0] y,
                                         color_t want);
    script.push_back('{1'b0, '0, '0, x, y, 1'b1, want});
  endfunction

  function automatic logic [DIM_W-1:0] pick_dim();
    case ($urandom_range(0, 9))
      0: begin
        case ($urandom_range(0, 4))
          0:       return 13'd0;
          1:       return 13'd1;
          2:       return 13'd2;
          3:       return 13'd4096;
          default: return 13'd8191;
        endcase
      end
      1:       return 13'($urandom_range(4097, 8191));
      2, 3, 4: return 13'($urandom_range(1, 16));
      default: return 13'($urandom_range(1, 4096));
    endcase
  endfunction

  function automatic logic [3*CH_W-1:0] pick_corner();
    case ($urandom_range(0, 9))
      0:       return 24'h000000;
      1:       return 24'hFFFFFF;
      default: return 24'($urandom_range(0, 24'hFFFFFF));
    endcase
  endfunction

  function automatic logic [PIX_W-1:0] pick_coord(longint unsigned lim);
    int r;
    r = $urandom_range(0, 9);
    if (lim == 0 || r == 0) return PIX_W'($urandom_range(0, 4095));
    if (r == 1) return PIX_W'(lim - 1);
    if (r == 2 && lim <= 4095) return PIX_W'(lim);
    return PIX_W'($urandom_range(0, int'(lim - 1)));
  endfunction

  initial begin
    bit                  idle;
    bit                  gaps_on;
    longint unsigned     ew, eh;
    logic [DIM_W-1:0]    dim;

    regs = '{RESET_TL, RESET_TR, RESET_BL, RESET_BR, RESET_W, RESET_H};

    // power-on colors and frame edges
    add_pixel_want(0, 0, color_t'({24'hFF0000, 1'b0}));
    add_pixel_want(639, 0, color_t'({24'h0000FF, 1'b0}));
    add_pixel_want(0, 479, color_t'({24'hFFFF00, 1'b0}));
    add_pixel_want(639, 479, color_t'({24'h00FF00, 1'b0}));
    add_pixel_want(640, 0, OFF_FRAME);
    add_pixel_want(0, 480, OFF_FRAME);
    add_pixel_want(4095, 4095, OFF_FRAME);
    add_pixel(320, 240);
    // single pixel frame
    add_reg(CFG_W, 24'd1);
    add_reg(CFG_H, 24'd1);
    add_pixel_want(0, 0, color_t'({24'hFF0000, 1'b0}));
    add_pixel_want(1, 0, OFF_FRAME);
    add_pixel_want(0, 1, OFF_FRAME);
    // empty frame
    add_reg(CFG_W, 24'd0);
    add_pixel_want(0, 0, OFF_FRAME);
    // oversize frame clamps to the maximum
    add_reg(CFG_W, 24'd8191);
    add_reg(CFG_H, 24'd8191);
    add_pixel_want(4095, 4095, color_t'({24'h00FF00, 1'b0}));
    add_pixel_want(4095, 0, color_t'({24'h0000FF, 1'b0}));
    add_reg(CFG_TL, 24'hFFFFFF);
    add_reg(CFG_TR, 24'h000000);
    add_reg(CFG_BL, 24'h000000);
    add_reg(CFG_BR, 24'hFFFFFF);
    add_reg(CFG_W, 24'd3);
    add_reg(CFG_H, 24'd3);
    add_pixel(1, 1);
    add_pixel(2, 1);
    add_pixel_want(3, 0, OFF_FRAME);
    // one row: vertical weight drops out
    add_reg(CFG_W, 24'd2);
    add_reg(CFG_H, 24'd1);
    add_pixel_want(1, 0, color_t'({24'h000000, 1'b0}));
    add_pixel_want(0, 0, color_t'({24'hFFFFFF, 1'b0}));
    // unused indexes leave the registers alone
    add_reg(IDX_SPARE_LO, 24'h000000);
    add_reg(IDX_SPARE_HI, 24'h123456);
    add_pixel_want(0, 0, color_t'({24'hFFFFFF, 1'b0}));
    // exact half rounds up
    add_reg(CFG_TL, 24'h010101);
    add_reg(CFG_BR, 24'h000000);
    add_reg(CFG_W, 24'd3);
    add_reg(CFG_H, 24'd2);
    add_pixel_want(1, 0, color_t'({24'h010101, 1'b0}));
    // largest frame
    add_reg(CFG_TL, 24'hA5C3F0);
    add_reg(CFG_TR, 24'h5A3C0F);
    add_reg(CFG_BL, 24'h0F0F0F);
    add_reg(CFG_BR, 24'hF0F0F0);
    add_reg(CFG_W, 24'd4096);
    add_reg(CFG_H, 24'd4096);
    add_pixel(2048, 2048);
    add_pixel(4095, 1);
    add_pixel(0, 4095);
    add_pixel(1234, 3000);

    repeat (4) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    idle = 1'b1;
    foreach (script[i]) begin
      if (script[i].is_reg) begin
        if (!idle) drain_pipeline();
        idle = 1'b1;
        write_reg(script[i].idx, script[i].data);
      end else begin
        issue_pixel(script[i].x, script[i].y, $urandom_range(0, MAX_GAP),
                    script[i].typed, script[i].want);
        idle = 1'b0;
      end
    end

    for (int phase = 0; phase < PHASES; phase++) begin
      drain_pipeline();
      write_reg(CFG_TL, pick_corner());
      write_reg(CFG_TR, pick_corner());
      write_reg(CFG_BL, pick_corner());
      write_reg(CFG_BR, pick_corner());
      dim = (phase == 0) ? 13'd4096 : pick_dim();
      write_reg(CFG_W, {11'($urandom_range(0, 2047)), dim});
      dim = (phase == 0) ? 13'd4096 : pick_dim();
      write_reg(CFG_H, {11'($urandom_range(0, 2047)), dim});
      if ($urandom_range(0, 3) == 0)
        write_reg($urandom_range(0, 1) ? IDX_SPARE_HI : IDX_SPARE_LO,
                  24'($urandom_range(0, 24'hFFFFFF)));
      ew = clamp_dim(regs.w, MAX_DIM_X);
      eh = clamp_dim(regs.h, MAX_DIM_Y);
      gaps_on = (phase % 3 != 1);
      repeat (RANDOM_ITEMS / PHASES)
        issue_pixel(pick_coord(ew), pick_coord(eh),
                    gaps_on ? $urandom_range(0, MAX_GAP) : 0, 1'b0, '0);
    end

    drain_pipeline();
    if (error_count == 0) $display("tb_bilinear_gradient_color: clean");
    else $display("tb_bilinear_gradient_color: errors");
    $finish;
  end

endmodule
